// File: rtl/imsbe_pkg.sv
// Shared types, widths and register codes for the IR mark/space bit encoder.
package imsbe_pkg;

    localparam int UnitW     = 16;
    localparam int LenW      = 18;
    localparam int MaxRes    = 3;
    localparam int ResCntW   = 2;
    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;
    localparam int FifoCntW  = 3;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 24;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 32;

    localparam logic MODE_MANCHESTER = 1'b0;
    localparam logic MODE_PULSE_DIST = 1'b1;

    typedef enum logic [0:0] {
        REG_UNIT_LENGTH = 1'b0,
        REG_CODING_MODE = 1'b1
    } reg_idx_t;

    typedef logic [LenW-1:0] len_t;

    typedef struct packed {
        len_t run_length;
        logic is_mark;
        logic final_run;
    } result_t;

    typedef struct packed {
        logic [UnitW-1:0] unit_length;
        logic             coding_mode;
    } cfg_t;

    // Result beats produced by one input item, beat[0] first.
    typedef struct packed {
        logic [ResCntW-1:0]       count;
        result_t [MaxRes-1:0]     beat;
    } push_t;

endpackage

// File: rtl/imsbe_cfg.sv
// APB register file: unit length and coding mode.
module imsbe_cfg
    import imsbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_UNIT_LENGTH: cfg_next.unit_length = pwdata[UnitW-1:0];
                REG_CODING_MODE: cfg_next.coding_mode = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_UNIT_LENGTH: prdata = {{(CfgDataW-UnitW){1'b0}}, cfg_reg.unit_length};
            REG_CODING_MODE: prdata = {{(CfgDataW-1){1'b0}}, cfg_reg.coding_mode};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/imsbe_step.sv
// Per-bit encoder: splits a code bit into two halves and merges them into runs.
module imsbe_step
    import imsbe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  code_bit,
    input  logic  frame_end,
    input  cfg_t  cfg,
    output push_t push
);

    logic run_started_reg;
    logic run_started_next;
    logic run_level_reg;
    logic run_level_next;
    len_t pending_length_reg;
    len_t pending_length_next;

    always_comb
    begin : encode
        logic               st;
        logic               lvl;
        len_t               pend;
        logic [ResCntW-1:0] n;
        logic [LenW:0]      sum;
        len_t               u1;
        len_t               u3;
        logic [1:0]         h_lvl;
        len_t               h_len [2];

        u1 = {{(LenW-UnitW){1'b0}}, cfg.unit_length};
        u3 = u1 + {u1[LenW-2:0], 1'b0};

        if (cfg.coding_mode == MODE_MANCHESTER)
        begin
            h_lvl[0] = ~code_bit;
            h_lvl[1] = code_bit;
            h_len[0] = u1;
            h_len[1] = u1;
        end
        else
        begin
            h_lvl[0] = 1'b1;
            h_lvl[1] = 1'b0;
            h_len[0] = u1;
            h_len[1] = code_bit ? u3 : u1;
        end

        st        = run_started_reg;
        lvl       = run_level_reg;
        pend      = pending_length_reg;
        n         = '0;
        sum       = '0;
        push.beat = '0;

        for (int k = 0; k < 2; k++)
        begin
            if (!st)
            begin
                // Frame opening on a space: lead with an empty mark.
                if (!h_lvl[k])
                begin
                    push.beat[n] = '{run_length: '0, is_mark: 1'b1, final_run: 1'b0};
                    n = n + 1'b1;
                end
                st   = 1'b1;
                lvl  = h_lvl[k];
                pend = h_len[k];
            end
            else if (h_lvl[k] == lvl)
            begin
                sum  = {1'b0, pend} + {1'b0, h_len[k]};
                pend = sum[LenW] ? '1 : sum[LenW-1:0];
            end
            else
            begin
                push.beat[n] = '{run_length: pend, is_mark: lvl, final_run: 1'b0};
                n    = n + 1'b1;
                lvl  = h_lvl[k];
                pend = h_len[k];
            end
        end

        // Flush the pending run and drop back to the idle frame state.
        if (frame_end)
        begin
            push.beat[n] = '{run_length: pend, is_mark: lvl, final_run: 1'b1};
            n    = n + 1'b1;
            st   = 1'b0;
            lvl  = 1'b0;
            pend = '0;
        end

        push.count          = n;
        run_started_next    = accept ? st   : run_started_reg;
        run_level_next      = accept ? lvl  : run_level_reg;
        pending_length_next = accept ? pend : pending_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_started_reg    <= 1'b0;
            run_level_reg      <= 1'b0;
            pending_length_reg <= '0;
        end
        else
        begin
            run_started_reg    <= run_started_next;
            run_level_reg      <= run_level_next;
            pending_length_reg <= pending_length_next;
        end
    end

endmodule

// File: rtl/imsbe_fifo.sv
// Result queue: takes up to three beats per cycle, drains one beat per cycle while out_ready is high.
module imsbe_fifo
    import imsbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_en,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_beat
);

    result_t             mem [FifoDepth];
    logic [FifoAw-1:0]   wr_ptr_reg;
    logic [FifoAw-1:0]   wr_ptr_next;
    logic [FifoAw-1:0]   rd_ptr_reg;
    logic [FifoAw-1:0]   rd_ptr_next;
    logic [FifoCntW-1:0] count_reg;
    logic [FifoCntW-1:0] count_next;
    logic [FifoCntW-1:0] push_cnt;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= FifoCntW'(FifoDepth - MaxRes));
    assign push_cnt  = push_en ? FifoCntW'(push.count) : '0;
    assign out_beat  = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + push_cnt[FifoAw-1:0];
    assign rd_ptr_next = rd_ptr_reg + FifoAw'(pop);
    assign count_next  = count_reg + push_cnt - FifoCntW'(pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MaxRes; k++)
        begin
            if (push_en && (ResCntW'(k) < push.count))
            begin
                mem[wr_ptr_reg + FifoAw'(k)] <= push.beat[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/ir_mark_space_bit_encoder_core.sv
// Top level of the IR mark/space bit encoder: stream in, stream out, APB setup.
//
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | tdata[0] code_bit, tlast frame_end
//  m_axis    | out       | tdata[17:0] run_length, tuser is_mark, tlast final_run
//  apb       | in/out    | 0x0 unit_length[15:0], 0x4 coding_mode[0]
//
// Each accepted bit is encoded in the cycle it is accepted and yields one to
// three beats, which enter a four-entry result queue and are offered on the
// output in order. The queue drains one beat per cycle while the output is
// ready; a stalled output holds the queue.
// A new bit is taken whenever the queue holds at most one beat, even while
// that beat is stalled on the output side.
// Reset clears the frame state, the registers and the queue; no clearing pass.
module ir_mark_space_bit_encoder_core
    import imsbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Input beats.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // [0] code_bit, [7:1] zero
    input  logic                s_axis_tlast,   // frame_end
    // Result beats.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // [17:0] run_length, [23:18] zero
    output logic                m_axis_tuser,   // is_mark
    output logic                m_axis_tlast,   // final_run
    // Configuration.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready
);

    cfg_t    cfg;
    push_t   push;
    result_t out_beat;
    logic    room;
    logic    accept;

    // Hold input off while the queue could not absorb a worst-case bit.
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    imsbe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Encode the bit against the pending run; state advances on accept only.
    imsbe_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_bit  (s_axis_tdata[0]),
        .frame_end (s_axis_tlast),
        .cfg       (cfg),
        .push      (push)
    );

    imsbe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_beat  (out_beat)
    );

    assign m_axis_tdata = {{(OutDataW-LenW){1'b0}}, out_beat.run_length};
    assign m_axis_tuser = out_beat.is_mark;
    assign m_axis_tlast = out_beat.final_run;

endmodule

// File: rtl/imsbe_checker.sv
// Port-level checks for the IR mark/space bit encoder, bound to the top level.
module imsbe_checker
    import imsbe_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [InDataW-1:0]  s_axis_tdata,
    input logic                s_axis_tlast,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata,
    input logic                m_axis_tuser,
    input logic                m_axis_tlast
);

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // Every accepted bit yields at least one result beat.
    a_bit_yields: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted bit produced no result");

    // Padding above run_length stays zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:LenW] == '0))
        else $error("result padding not zero");

    // With a result beat stalled on the output, an accepted bit must close the input.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready
            |=> !s_axis_tready)
        else $error("input accepted with queue too full");

endmodule

bind ir_mark_space_bit_encoder_core imsbe_checker u_imsbe_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the IR mark/space bit encoder core.
`timescale 1ns / 1ps

module tb_top;
    import imsbe_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 10;
    localparam int LongHold    = 300;

    // Predicts the mark/space runs that each code bit causes and holds them
    // until the matching result beats come out.
    class run_scoreboard;
        logic [UnitW-1:0] unit_length;
        logic             coding_mode;
        logic             run_started;
        logic             run_level;
        len_t             pending_length;
        result_t          expected_runs[$];
        int               errors;

        function new();
            unit_length    = '0;
            coding_mode    = MODE_MANCHESTER;
            run_started    = 1'b0;
            run_level      = 1'b0;
            pending_length = '0;
            errors         = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CfgDataW-1:0] value);
            if (idx == REG_UNIT_LENGTH)
                unit_length = value[UnitW-1:0];
            else
                coding_mode = value[0];
        endfunction

        function void push_run(len_t len, logic mark, logic fin);
            result_t r;
            r.run_length = len;
            r.is_mark    = mark;
            r.final_run  = fin;
            expected_runs.push_back(r);
        endfunction

        // Merge one half of a bit into the pending run, or close that run.
        function void add_half(logic level, len_t len);
            logic [LenW:0] sum;
            if (!run_started)
            begin
                if (level == 1'b0)
                    push_run('0, 1'b1, 1'b0);
                run_started    = 1'b1;
                run_level      = level;
                pending_length = len;
            end
            else if (level == run_level)
            begin
                sum = {1'b0, pending_length} + {1'b0, len};
                pending_length = sum[LenW] ? {LenW{1'b1}} : sum[LenW-1:0];
            end
            else
            begin
                push_run(pending_length, run_level, 1'b0);
                run_level      = level;
                pending_length = len;
            end
        endfunction

        function void note_bit(logic code_bit, logic frame_end);
            len_t u;
            u = len_t'(unit_length);
            if (coding_mode == MODE_MANCHESTER)
            begin
                add_half(!code_bit, u);
                add_half(code_bit, u);
            end
            else
            begin
                add_half(1'b1, u);
                add_half(1'b0, code_bit ? len_t'(u * 3) : u);
            end
            if (frame_end)
            begin
                push_run(pending_length, run_level, 1'b1);
                run_started    = 1'b0;
                run_level      = 1'b0;
                pending_length = '0;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_beat(logic [OutDataW-1:0] tdata, logic tuser, logic tlast);
            result_t want;
            if (expected_runs.size() == 0)
            begin
                report_mismatch($sformatf(
                    "beat with nothing expected: len %0d mark %0b last %0b",
                    tdata[LenW-1:0], tuser, tlast));
                return;
            end
            want = expected_runs.pop_front();
            if (tdata[LenW-1:0] !== want.run_length)
                report_mismatch($sformatf("run_length %0d, expected %0d",
                                          tdata[LenW-1:0], want.run_length));
            if (tuser !== want.is_mark)
                report_mismatch($sformatf("is_mark %0b, expected %0b",
                                          tuser, want.is_mark));
            if (tlast !== want.final_run)
                report_mismatch($sformatf("final_run %0b, expected %0b",
                                          tlast, want.final_run));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;   // [0] code_bit, [7:1] zero
    logic                s_axis_tlast;   // frame_end
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;   // [17:0] run_length, [23:18] zero
    logic                m_axis_tuser;   // is_mark
    logic                m_axis_tlast;   // final_run
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [CfgDataW-1:0] pwdata;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    run_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    logic          hold_req;
    int            cycles;

    ir_mark_space_bit_encoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: pick tready at the falling edge. A long hold-off request keeps
    // tready low so the result queue fills and the input
    // side has to stall while the sender keeps offering beats.
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            hold_req = 1'b0;
            m_axis_tready <= 1'b0;
            repeat (LongHold) @(negedge clk);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: check every result beat taken at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Write one register with a setup and an access phase.
    task apb_write(reg_idx_t idx, logic [CfgDataW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CfgAddrW'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task set_config(int unit, logic mode);
        apb_write(REG_UNIT_LENGTH, CfgDataW'(unit));
        apb_write(REG_CODING_MODE, CfgDataW'(mode));
    endtask

    // Offer one code bit, idling first at the sender's rate, and hold it
    // until the block takes it.
    task send_bit(logic code_bit, logic frame_end);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-1){1'b0}}, code_bit};
        s_axis_tlast  <= frame_end;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_bit(code_bit, frame_end);
    endtask

    // Drop valid and wait until every predicted run has come out, then let
    // the pipeline settle before anything touches the registers.
    task drain;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_runs.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Mostly whole frames with random bits; the rest are loose bits with a
    // random frame end, which break frames at odd places.
    task send_frames(int count, bit pause_midway);
        int sent;
        int len;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            if (pause_midway && !paused && sent >= count / 2)
            begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(0, 9) < 8)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_bit(1'($urandom_range(0, 1)), i == len - 1);
                sent += len;
            end
            else
            begin
                send_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        int unit;
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cycles         = 0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers give a zero unit length in Manchester mode;
        // a leading one opens the frame with a space, so a zero mark comes first.
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        drain();

        // Longest unit, Manchester: merged halves reach twice the unit.
        set_config(65535, MODE_MANCHESTER);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b1);
        drain();

        // Pulse distance at the longest unit: a one gives a triple space.
        apb_write(REG_CODING_MODE, CfgDataW'(MODE_PULSE_DIST));
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b0);
        drain();

        // Switch coding in the middle of a frame: the open triple space keeps
        // growing under Manchester.
        apb_write(REG_CODING_MODE, CfgDataW'(MODE_MANCHESTER));
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        drain();

        // Unit of one, pulse distance coding.
        set_config(1, MODE_PULSE_DIST);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        drain();

        // Random phases: walk the idle patterns under both codings, with the
        // extreme unit lengths among the settings.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0, 4:    unit = 65535;
                1, 5:    unit = 0;
                3:       unit = 1;
                7:       unit = $urandom_range(0, 15);
                default: unit = $urandom_range(0, 65535);
            endcase
            set_config(unit, (p >= 4) ? MODE_PULSE_DIST : MODE_MANCHESTER);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            // Hold the receiver off for a long stretch while bits keep coming.
            if (p == 0 || p == 4)
                hold_req = 1'b1;
            send_frames(40, p == 1 || p == 6);
            drain();
        end

        if (sb.expected_runs.size() != 0)
            sb.report_mismatch($sformatf("%0d runs never came out", sb.expected_runs.size()));
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
